// File: rtl/pa_pkg.sv
// Shared types and constants for the primitive assembly block.
// Used by pa_front, pa_queue, pa_back and primitive_assembly_core.
package pa_pkg;

    localparam int MAX_BLOCK_VERTS = 4096;
    localparam int CNT_W           = $clog2(MAX_BLOCK_VERTS + 1);
    localparam int WORD_W          = 32;
    localparam int NWORDS          = 7;
    localparam int VERT_W          = WORD_W * NWORDS;
    localparam int NRES            = 6;
    localparam int NUM_W           = $clog2(NRES + 1);
    localparam int IDX_W           = $clog2(NRES);
    localparam int QDEPTH          = 2;
    localparam int QPTR_W          = $clog2(QDEPTH);
    localparam int QCNT_W          = $clog2(QDEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCK_VERTS);

    // Primitive modes.
    localparam logic [3:0] MODE_POINTS     = 4'd0;
    localparam logic [3:0] MODE_LINES      = 4'd1;
    localparam logic [3:0] MODE_LINE_STRIP = 4'd2;
    localparam logic [3:0] MODE_LINE_LOOP  = 4'd3;
    localparam logic [3:0] MODE_TRIS       = 4'd4;
    localparam logic [3:0] MODE_TRI_STRIP  = 4'd5;
    localparam logic [3:0] MODE_FAN        = 4'd6;
    localparam logic [3:0] MODE_POLYGON    = 4'd7;
    localparam logic [3:0] MODE_QUADS      = 4'd8;
    localparam logic [3:0] MODE_QUAD_STRIP = 4'd9;
    localparam logic [3:0] MODE_RESET      = MODE_TRIS;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_MODE = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] alpha;
        logic [WORD_W-1:0] blue;
        logic [WORD_W-1:0] green;
        logic [WORD_W-1:0] red;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] x;
    } t_vertex;

    // Where one result takes its data from.
    typedef enum logic [2:0] {
        SRC_FIRST,
        SRC_P1,
        SRC_P2,
        SRC_P3,
        SRC_CUR,
        SRC_BAD_MODE,
        SRC_OVERFLOW
    } t_src;

    // One classified item as handed from the front to the back.
    typedef struct packed {
        t_vertex              vert;
        t_src [NRES-1:0]      src;
        logic [NUM_W-1:0]     num;
        logic                 store;
        logic                 first;
    } t_cmd;

endpackage

// File: rtl/pa_front.sv
// Front end: accepts vertices, tracks the block position and builds the result list.
// Depends on pa_pkg.
module pa_front
    import pa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    input  logic        i_valid,
    input  t_vertex     i_vert,
    input  logic        i_last,
    input  logic        i_full,
    output logic        o_ready,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [3:0]       r_prim_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [1:0]       r_phase, n_phase;

    logic             accept;
    logic             overflow;
    logic [CNT_W-1:0] count_inc;
    t_src             a_src [NRES];
    logic [NUM_W-1:0] a_num;
    t_src             e_src [2];
    logic [NUM_W-1:0] e_num;

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign o_push    = accept;
    assign overflow  = (r_count == CNT_MAX);
    assign count_inc = overflow ? CNT_MAX : r_count + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prim_mode <= MODE_RESET;
        end else if (i_cfg_wr_en) begin
            r_prim_mode <= i_cfg_wr_data;
        end
    end

    // Results that the new vertex itself completes.
    always_comb begin
        for (int k = 0; k < NRES; k++) begin
            a_src[k] = SRC_CUR;
        end
        a_num = '0;
        if (overflow) begin
            a_src[0] = SRC_OVERFLOW;
            a_num    = NUM_W'(1);
        end else begin
            unique case (r_prim_mode)
                MODE_POINTS: begin
                    a_num = NUM_W'(1);
                end
                MODE_LINES: begin
                    if (r_count[0]) begin
                        a_src[0] = SRC_P1;
                        a_num    = NUM_W'(2);
                    end
                end
                MODE_LINE_STRIP, MODE_LINE_LOOP: begin
                    if (r_count != '0) begin
                        a_src[0] = SRC_P1;
                        a_num    = NUM_W'(2);
                    end
                end
                MODE_TRIS: begin
                    if (r_phase == 2'd2) begin
                        a_src[0] = SRC_P2;
                        a_src[1] = SRC_P1;
                        a_num    = NUM_W'(3);
                    end
                end
                MODE_TRI_STRIP: begin
                    if (r_count >= CNT_W'(2)) begin
                        // Odd triangles of the strip swap the first two corners.
                        a_src[0] = r_count[0] ? SRC_P1 : SRC_P2;
                        a_src[1] = r_count[0] ? SRC_P2 : SRC_P1;
                        a_num    = NUM_W'(3);
                    end
                end
                MODE_FAN, MODE_POLYGON: begin
                    if (r_count >= CNT_W'(2)) begin
                        a_src[0] = SRC_FIRST;
                        a_src[1] = SRC_P1;
                        a_num    = NUM_W'(3);
                    end
                end
                MODE_QUADS: begin
                    if (r_count[1:0] == 2'd3) begin
                        a_src[0] = SRC_P3;
                        a_src[1] = SRC_P2;
                        a_src[2] = SRC_P1;
                        a_src[3] = SRC_P3;
                        a_src[4] = SRC_P1;
                        a_num    = NUM_W'(6);
                    end
                end
                MODE_QUAD_STRIP: begin
                    if (r_count >= CNT_W'(3) && r_count[0]) begin
                        a_src[0] = SRC_P3;
                        a_src[1] = SRC_P2;
                        a_src[3] = SRC_P3;
                        a_src[5] = SRC_P1;
                        a_num    = NUM_W'(6);
                    end
                end
                default: begin
                    a_num = '0;
                end
            endcase
        end
    end

    // Results owed at block end.
    always_comb begin
        e_src[0] = SRC_BAD_MODE;
        e_src[1] = SRC_FIRST;
        e_num    = '0;
        if (i_last) begin
            if (r_prim_mode > MODE_QUAD_STRIP) begin
                e_num = NUM_W'(1);
            end else if (r_prim_mode == MODE_LINE_LOOP && count_inc > CNT_W'(2)) begin
                // The last stored vertex is this one unless it was dropped.
                e_src[0] = overflow ? SRC_P1 : SRC_CUR;
                e_num    = NUM_W'(2);
            end
        end
    end

    always_comb begin
        o_cmd.vert  = i_vert;
        o_cmd.num   = a_num + e_num;
        o_cmd.store = !overflow;
        o_cmd.first = (r_count == '0);
        for (int k = 0; k < NRES; k++) begin
            if (NUM_W'(k) < a_num) begin
                o_cmd.src[k] = a_src[k];
            end else if (NUM_W'(k) - a_num == NUM_W'(0)) begin
                o_cmd.src[k] = e_src[0];
            end else begin
                o_cmd.src[k] = e_src[1];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_phase = r_phase;
        if (accept) begin
            if (!overflow) begin
                n_count = count_inc;
                n_phase = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
            end
            if (i_last) begin
                n_count = '0;
                n_phase = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_phase <= 2'd0;
        end else begin
            r_count <= n_count;
            r_phase <= n_phase;
        end
    end

endmodule

// File: rtl/pa_queue.sv
// Short command queue between the front end and the back end.
// Depends on pa_pkg.
module pa_queue
    import pa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

endmodule

// File: rtl/pa_back.sv
// Back end: holds the vertex history and emits one result per cycle unless stalled.
// Depends on pa_pkg.
module pa_back
    import pa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    input  logic        i_ready,
    output logic        o_valid,
    output t_vertex     o_vert,
    output logic [1:0]  o_status,
    output logic        o_last
);

    t_vertex           r_first, r_p1, r_p2, r_p3;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_o_valid, n_o_valid;
    t_vertex           r_o_vert;
    logic [1:0]        r_o_status;
    logic              r_o_last;

    logic              out_free;
    logic              work;
    logic              load;
    logic              final_res;
    t_src              cur_src;
    t_vertex           sel_vert;
    logic [1:0]        sel_status;

    assign out_free  = !r_o_valid || i_ready;
    assign work      = !i_empty && out_free;
    assign load      = work && (i_cmd.num != '0);
    assign final_res = (NUM_W'(r_idx) + NUM_W'(1) == i_cmd.num);
    // A command with no results retires at once; otherwise with its last result.
    assign o_pop     = work && ((i_cmd.num == '0) || final_res);
    assign cur_src   = i_cmd.src[r_idx];

    always_comb begin
        sel_vert   = '0;
        sel_status = ST_OK;
        case (cur_src)
            SRC_FIRST:    sel_vert = r_first;
            SRC_P1:       sel_vert = r_p1;
            SRC_P2:       sel_vert = r_p2;
            SRC_P3:       sel_vert = r_p3;
            SRC_CUR:      sel_vert = i_cmd.vert;
            SRC_BAD_MODE: sel_status = ST_BAD_MODE;
            SRC_OVERFLOW: sel_status = ST_OVERFLOW;
            default:      sel_status = ST_OK;
        endcase
    end

    always_comb begin
        n_idx     = r_idx;
        n_o_valid = r_o_valid;
        if (i_ready) begin
            n_o_valid = 1'b0;
        end
        if (load) begin
            n_o_valid = 1'b1;
            n_idx     = final_res ? '0 : r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_idx     <= n_idx;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_vert   <= sel_vert;
            r_o_status <= sel_status;
            r_o_last   <= final_res;
        end
        // History moves only when the item's results have all been read out of it.
        if (o_pop && i_cmd.store) begin
            r_p3 <= r_p2;
            r_p2 <= r_p1;
            r_p1 <= i_cmd.vert;
            if (i_cmd.first) begin
                r_first <= i_cmd.vert;
            end
        end
    end

    assign o_valid  = r_o_valid;
    assign o_vert   = r_o_vert;
    assign o_status = r_o_status;
    assign o_last   = r_o_last;

endmodule

// File: rtl/primitive_assembly_core.sv
// Primitive assembly: turns a stream of block vertices into point, line and
// triangle vertex lists. Depends on pa_pkg, pa_front, pa_queue and pa_back.
//
// Usage:
// - The slave stream carries one vertex per item; tlast marks the final vertex
//   of a begin/end block. The master stream carries one emitted vertex per item,
//   with tuser giving its status and tlast marking the last result of an input.
// - The primitive mode is written through i_cfg_wr_en/i_cfg_wr_data while the
//   block is idle; reset selects separate triangles.
// - The front end classifies each vertex in the cycle it is accepted and queues
//   a command in a two-entry queue; the back end emits one result per cycle from
//   the vertex history it keeps, while the receiver is ready.
// - An accepted item passes through the queue, and its first result is loaded
//   into the output register from there as soon as the queue holds nothing
//   older and the output register is free.
// - The back end emits the results of an item one at a time, an item with no
//   results still taking a turn; triangle strips and fans give three results per
//   vertex, quads six per fourth vertex. The emit stage is the limiting unit.
// - When the receiver stalls the output register holds its result, the queue
//   fills and s_axis_tready falls only once both entries are taken.
// - Reset empties the queue and output register and returns to a fresh block.
module primitive_assembly_core
    import pa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [3:0]         i_cfg_wr_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // x_word, y_word, z_word, red_word, green_word, blue_word, alpha_word
    input  logic [VERT_W-1:0]  s_axis_tdata,
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // out_x, out_y, out_z, out_red, out_green, out_blue, out_alpha
    output logic [VERT_W-1:0]  m_axis_tdata,
    // status
    output logic [1:0]         m_axis_tuser,
    output logic               m_axis_tlast
);

    logic    q_push, q_pop, q_full, q_empty;
    t_cmd    push_cmd, head_cmd;
    t_vertex out_vert;

    pa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .i_vert        (t_vertex'(s_axis_tdata)),
        .i_last        (s_axis_tlast),
        .i_full        (q_full),
        .o_ready       (s_axis_tready),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    pa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    pa_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_cmd    (head_cmd),
        .o_pop    (q_pop),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_vert   (out_vert),
        .o_status (m_axis_tuser),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = VERT_W'(out_vert);

endmodule

// File: bench/primitive_assembly_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for primitive_assembly_core: sends vertex blocks in every
// primitive mode, predicts the emitted vertex lists and checks every result item.
// Depends on pa_pkg and the RTL of the block.
module primitive_assembly_core_test;
    import pa_pkg::*;

    localparam logic [3:0] MODE_BAD_LO   = 4'd10;
    localparam logic [3:0] MODE_BAD_HI   = 4'd15;
    localparam int         CYCLE_LIMIT   = 500000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         RANDOM_ITEMS  = 360;

    typedef struct {
        t_vertex    vert;
        logic [1:0] status;
        logic       run_end;
    } t_emitted;

    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE
    } t_rx_style;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [3:0]        i_cfg_wr_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [VERT_W-1:0] s_axis_tdata;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [VERT_W-1:0] m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              m_axis_tlast;

    // Predictor state: first vertex and the three most recent, vertex count, mode.
    t_vertex          vert_hist [4];
    t_vertex          cur_vert;
    logic [CNT_W-1:0] block_count;
    logic [3:0]       cur_mode;
    t_emitted         expected_vertices [$];
    int               run_len;

    int        errors          = 0;
    int        items_sent      = 0;
    int        blocks_sent     = 0;
    int        results_checked = 0;
    int        cycle_count     = 0;
    int        burst_left      = 0;
    bit        steady_send     = 1'b0;
    int        rx_hold         = 0;
    int        rx_left         = 0;
    t_rx_style rx_style        = RX_OPEN;

    primitive_assembly_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_vertex slot_vertex(input t_src s);
        return (s == SRC_CUR) ? cur_vert : vert_hist[2'(s)];
    endfunction

    task automatic queue_vertex(input t_src s);
        t_emitted e;
        e.vert    = slot_vertex(s);
        e.status  = ST_OK;
        e.run_end = 1'b0;
        expected_vertices.push_back(e);
        run_len++;
    endtask

    task automatic push_status(input logic [1:0] st);
        t_emitted e;
        e.vert    = '0;
        e.status  = st;
        e.run_end = 1'b0;
        expected_vertices.push_back(e);
        run_len++;
    endtask

    task automatic push_triangle(input t_src a, input t_src b, input t_src c);
        queue_vertex(a);
        queue_vertex(b);
        queue_vertex(c);
    endtask

    // Works out the vertices that one accepted item emits and queues them.
    task automatic assemble_expected(input t_vertex v, input logic eob);
        logic [CNT_W-1:0] c;
        run_len  = 0;
        cur_vert = v;
        if (block_count >= CNT_MAX) begin
            block_count = CNT_MAX;
            push_status(ST_OVERFLOW);
        end else begin
            c = block_count;
            case (cur_mode)
                MODE_POINTS: queue_vertex(SRC_CUR);
                MODE_LINES: begin
                    if (c[0]) begin
                        queue_vertex(SRC_P1);
                        queue_vertex(SRC_CUR);
                    end
                end
                MODE_LINE_STRIP, MODE_LINE_LOOP: begin
                    if (c >= 1) begin
                        queue_vertex(SRC_P1);
                        queue_vertex(SRC_CUR);
                    end
                end
                MODE_TRIS: begin
                    if (c % 3 == 2) push_triangle(SRC_P2, SRC_P1, SRC_CUR);
                end
                MODE_TRI_STRIP: begin
                    // Odd triangles of a strip swap their first two vertices.
                    if (c >= 2) begin
                        if (c[0]) push_triangle(SRC_P1, SRC_P2, SRC_CUR);
                        else push_triangle(SRC_P2, SRC_P1, SRC_CUR);
                    end
                end
                MODE_FAN, MODE_POLYGON: begin
                    if (c >= 2) push_triangle(SRC_FIRST, SRC_P1, SRC_CUR);
                end
                MODE_QUADS: begin
                    if (c[1:0] == 2'b11) begin
                        push_triangle(SRC_P3, SRC_P2, SRC_P1);
                        push_triangle(SRC_P3, SRC_P1, SRC_CUR);
                    end
                end
                MODE_QUAD_STRIP: begin
                    if (c >= 3 && c[0]) begin
                        push_triangle(SRC_P3, SRC_P2, SRC_CUR);
                        push_triangle(SRC_P3, SRC_CUR, SRC_P1);
                    end
                end
                default: ;
            endcase
            vert_hist[2'(SRC_P3)] = vert_hist[2'(SRC_P2)];
            vert_hist[2'(SRC_P2)] = vert_hist[2'(SRC_P1)];
            vert_hist[2'(SRC_P1)] = v;
            if (c == 0) vert_hist[2'(SRC_FIRST)] = v;
            block_count = c + 1'b1;
        end
        if (eob) begin
            if (cur_mode > MODE_QUAD_STRIP) begin
                push_status(ST_BAD_MODE);
            end else if (cur_mode == MODE_LINE_LOOP && block_count > 2) begin
                queue_vertex(SRC_P1);
                queue_vertex(SRC_FIRST);
            end
            block_count = '0;
        end
        if (run_len > 0) expected_vertices[expected_vertices.size() - 1].run_end = 1'b1;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_vertex rand_vertex();
        t_vertex v;
        for (int i = 0; i < NWORDS; i++) v[i*WORD_W +: WORD_W] = rand_word();
        return v;
    endfunction

    // Sends one item; the sender works in bursts with random gaps in between.
    task automatic send_vertex(input t_vertex v, input logic eob);
        int gap;
        if (!steady_send && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= eob;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        assemble_expected(v, eob);
        items_sent++;
        if (eob) blocks_sent++;
    endtask

    task automatic send_block(input int len);
        for (int i = 0; i < len; i++) send_vertex(rand_vertex(), i == len - 1);
    endtask

    // Stops sending and waits until every expected result has come out.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_vertices.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_prim_mode(input logic [3:0] m);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        cur_mode = m;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Separate triangles straight after reset, with extreme word patterns.
    task automatic test_reset_mode();
        logic [WORD_W-1:0] pats [6] = '{'0, '1, 32'hAAAA_AAAA, 32'h5555_5555,
                                        32'h8000_0000, 32'h7FFF_FFFF};
        t_vertex v;
        for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < NWORDS; i++) v[i*WORD_W +: WORD_W] = pats[(k + i) % 6];
            send_vertex(v, k == 5);
        end
    endtask

    task automatic test_each_mode();
        logic [3:0] modes [12] = '{MODE_POINTS, MODE_LINES, MODE_LINE_STRIP, MODE_LINE_LOOP,
                                   MODE_LINE_LOOP, MODE_TRIS, MODE_TRI_STRIP, MODE_FAN,
                                   MODE_POLYGON, MODE_QUADS, MODE_QUAD_STRIP, MODE_BAD_HI};
        int lens [12] = '{1, 2, 2, 3, 2, 3, 4, 3, 3, 4, 4, 1};
        for (int i = 0; i < 12; i++) begin
            wait_idle();
            set_prim_mode(modes[i]);
            send_block(lens[i]);
        end
    endtask

    // The mode is changed between vertices of one block while it is idle.
    task automatic test_mode_switch();
        wait_idle();
        set_prim_mode(MODE_FAN);
        for (int i = 0; i < 3; i++) send_vertex(rand_vertex(), 1'b0);
        wait_idle();
        set_prim_mode(MODE_TRI_STRIP);
        for (int i = 0; i < 2; i++) send_vertex(rand_vertex(), 1'b0);
        wait_idle();
        set_prim_mode(MODE_BAD_LO);
        send_vertex(rand_vertex(), 1'b1);
    endtask

    // Fills a block to one short of capacity, later to capacity, while the mode is invalid,
    // so nothing comes out, then switches to a line loop to see the dropped vertices and the block end.
    task automatic test_block_overflow();
        wait_idle();
        set_prim_mode(MODE_BAD_HI);
        for (int i = 0; i < MAX_BLOCK_VERTS - 1; i++) send_vertex(rand_vertex(), 1'b0);
        wait_idle();
        set_prim_mode(MODE_LINE_LOOP);
        send_vertex(rand_vertex(), 1'b0);
        send_vertex(rand_vertex(), 1'b0);
        wait_idle();
        set_prim_mode(MODE_BAD_LO);
        send_vertex(rand_vertex(), 1'b1);
        wait_idle();
        set_prim_mode(MODE_BAD_HI);
        for (int i = 0; i < MAX_BLOCK_VERTS; i++) send_vertex(rand_vertex(), 1'b0);
        wait_idle();
        set_prim_mode(MODE_LINE_LOOP);
        send_vertex(rand_vertex(), 1'b1);
    endtask

    // The receiver holds off long enough for the input side to stall.
    task automatic test_backpressure();
        wait_idle();
        set_prim_mode(MODE_QUADS);
        rx_hold     = 300;
        steady_send = 1'b1;
        send_block(24);
        steady_send = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_blocks();
        int         start_count;
        int         len;
        logic [3:0] m;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 7) == 0) m = 4'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
            else m = 4'($urandom_range(MODE_POINTS, MODE_QUAD_STRIP));
            set_prim_mode(m);
            repeat ($urandom_range(2, 5)) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
                send_block(len);
            end
        end
    endtask

    // The receiver changes between fully open, half open and sparse stretches.
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            if (rx_left == 0) begin
                rx_style = t_rx_style'($urandom_range(0, 2));
                rx_left  = $urandom_range(20, 200);
            end
            rx_left = rx_left - 1;
            case (rx_style)
                RX_OPEN: m_axis_tready <= 1'b1;
                RX_HALF: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic void check_word(input string name, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] seen);
        if (want !== seen) begin
            $display("%0t: %s expected %h got %h", $time, name, want, seen);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_emitted e;
        t_vertex  got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_vertex'(m_axis_tdata);
            if (expected_vertices.size() == 0) begin
                $display("%0t: unexpected result expected none got tdata=%h tuser=%0d tlast=%0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                e = expected_vertices.pop_front();
                results_checked++;
                check_word("x", e.vert.x, got.x);
                check_word("y", e.vert.y, got.y);
                check_word("z", e.vert.z, got.z);
                check_word("red", e.vert.red, got.red);
                check_word("green", e.vert.green, got.green);
                check_word("blue", e.vert.blue, got.blue);
                check_word("alpha", e.vert.alpha, got.alpha);
                check_word("status", WORD_W'(e.status), WORD_W'(m_axis_tuser));
                check_word("tlast", WORD_W'(e.run_end), WORD_W'(m_axis_tlast));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_vertices.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        block_count   = '0;
        cur_mode      = MODE_RESET;
        for (int i = 0; i < 4; i++) vert_hist[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_mode();
        test_each_mode();
        test_mode_switch();
        test_block_overflow();
        test_backpressure();
        test_random_blocks();

        wait_idle();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d vertices in %0d blocks over all primitive modes; checked %0d results.",
                 items_sent, blocks_sent, results_checked);
        $display("Run included invalid modes, block overflow, mid-block mode changes and stalls.");
        if (errors == 0 && expected_vertices.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: primitive_assembly_core.f
rtl/pa_pkg.sv
rtl/pa_front.sv
rtl/pa_queue.sv
rtl/pa_back.sv
rtl/primitive_assembly_core.sv
bench/primitive_assembly_core_test.sv
